>>> rtl/mwlf_pkg.sv
// Shared constants, types and command/status structs for the moving-window line fit.
package mwlf_pkg;

  // Field widths
  localparam int X_W    = 24;
  localparam int Y_W    = 24;
  localparam int RES_W  = 32;
  localparam int WS_W   = 6;

  // Window register reset value and the smallest sample count that gives a fit
  localparam logic [WS_W-1:0] WS_RESET = 6'd20;
  localparam int MIN_SAMPLES = 5;

  // Default ring depth and the numerator width that follows from it
  localparam int WINDOW_MAX_DEF = 32;
  localparam int LOG_DEF        = $clog2(WINDOW_MAX_DEF);
  localparam int NUM_W_DEF      = (2 * X_W + LOG_DEF) + (X_W + LOG_DEF) + 1;

  // Fraction shifts: Q12.12 inputs to Q16.16 results
  localparam int SLOPE_SHIFT = 16;
  localparam int ICPT_SHIFT  = 4;

  // Divider: 32 quotient bits plus one extra bit for rounding
  localparam int QUOT_W    = RES_W;
  localparam int DIV_STEPS = QUOT_W + 1;

  // Product sequencer: six products, each in two 32-bit halves of the wide operand
  localparam int MUL_HALF  = 32;
  localparam int MUL_OPS   = 12;
  localparam int MUL_CNT_W = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD_OLD,
    ST_UPD_NEW,
    ST_CHECK_N,
    ST_MUL,
    ST_DRAIN,
    ST_CHECK_D,
    ST_DIV_S,
    ST_WAIT_S,
    ST_DIV_I,
    ST_WAIT_I,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_STEP,
    DV_DONE
  } div_state_e;

  // Products of the normal equations
  typedef enum logic [2:0] {
    PR_N_SXX,
    PR_SX_SX,
    PR_N_SXY,
    PR_SX_SY,
    PR_SXX_SY,
    PR_SX_SXY
  } prod_e;

  typedef struct packed {
    logic  load;
    logic  upd_old;
    logic  upd_new;
    logic  mul_go;
    prod_e mul_sel;
    logic  mul_hi;
    logic  div_start;
    logic  div_slope;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic d_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/mwlf_div.sv
// Iterative restoring divider with round-to-nearest and Q16.16 saturation.
module mwlf_div #(
  parameter int NUM_W = mwlf_pkg::NUM_W_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           slope_i,
  input  logic signed [NUM_W-1:0]        num_i,
  input  logic        [NUM_W-1:0]        den_i,
  output logic                           done_o,
  output logic        [mwlf_pkg::QUOT_W-1:0] quot_o
);
  import mwlf_pkg::*;

  localparam int SH_W  = NUM_W + SLOPE_SHIFT;
  localparam int HI_W  = SH_W - QUOT_W;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [QUOT_W:0] POS_LIM = {2'b00, {(QUOT_W-1){1'b1}}};
  localparam logic [QUOT_W:0] NEG_LIM = {2'b01, {(QUOT_W-1){1'b0}}};

  div_state_e state_q, state_d;

  logic [SH_W-1:0]      sh_q;
  logic [NUM_W-1:0]     den_q;
  logic                 neg_q;
  logic                 ovf_q;
  logic [NUM_W-1:0]     rem_q, rem_d;
  logic [DIV_STEPS-1:0] bits_q;
  logic [DIV_STEPS-1:0] quot_q;
  logic [CNT_W-1:0]     cnt_q;

  logic [NUM_W-1:0]     mag;
  logic [SH_W-1:0]      sh_in;
  logic [HI_W-1:0]      hi_part;
  logic [NUM_W-1:0]     hi_ext;
  logic                 ovf;
  logic [NUM_W:0]       trial;
  logic [NUM_W:0]       diff;
  logic                 ge;
  logic [DIV_STEPS:0]   q_inc;
  logic [QUOT_W:0]      q_rnd;

  // Scale the numerator magnitude by the fraction shift
  assign mag   = num_i[NUM_W-1] ? NUM_W'(-num_i) : num_i;
  assign sh_in = slope_i ? {mag, {SLOPE_SHIFT{1'b0}}}
                         : {{(SLOPE_SHIFT-ICPT_SHIFT){1'b0}}, mag, {ICPT_SHIFT{1'b0}}};

  // Quotient of 2^32 or more saturates either way
  assign hi_part = sh_q[SH_W-1:QUOT_W];
  assign hi_ext  = NUM_W'(hi_part);
  assign ovf     = hi_ext >= den_q;

  // One restoring step
  assign trial = {rem_q, bits_q[DIV_STEPS-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];

  // Round half up: the extra quotient bit is the half
  assign q_inc = {1'b0, quot_q} + 1'b1;
  assign q_rnd = q_inc[DIV_STEPS:1];

  // Sign and saturate
  always_comb begin
    if (ovf_q) begin
      quot_o = neg_q ? NEG_LIM[QUOT_W-1:0] : POS_LIM[QUOT_W-1:0];
    end else if (!neg_q) begin
      quot_o = (q_rnd > POS_LIM) ? POS_LIM[QUOT_W-1:0] : q_rnd[QUOT_W-1:0];
    end else begin
      quot_o = (q_rnd >= NEG_LIM) ? NEG_LIM[QUOT_W-1:0] : QUOT_W'(-q_rnd[QUOT_W-1:0]);
    end
  end

  assign done_o = (state_q == DV_DONE);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      DV_IDLE: begin
        if (start_i) state_d = DV_CHECK;
      end
      DV_CHECK: begin
        state_d = ovf ? DV_DONE : DV_STEP;
      end
      DV_STEP: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = DV_DONE;
      end
      DV_DONE: begin
        state_d = DV_IDLE;
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (state_q == DV_CHECK) begin
      cnt_q <= '0;
    end else if (state_q == DV_STEP) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Operands, remainder and quotient
  always_ff @(posedge clk_i) begin
    case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          sh_q  <= sh_in;
          den_q <= den_i;
          neg_q <= num_i[NUM_W-1];
        end
      end
      DV_CHECK: begin
        ovf_q  <= ovf;
        rem_q  <= hi_ext;
        bits_q <= {sh_q[QUOT_W-1:0], 1'b0};
      end
      DV_STEP: begin
        rem_q  <= rem_d;
        bits_q <= {bits_q[DIV_STEPS-2:0], 1'b0};
        quot_q <= {quot_q[DIV_STEPS-2:0], ge};
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/mwlf_datapath.sv
// Datapath: sample ring, running sums, product sequencer, divider and result register.
module mwlf_datapath #(
  parameter int WINDOW_MAX = mwlf_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic        [mwlf_pkg::WS_W-1:0]  cfg_wdata_i,
  input  logic signed [mwlf_pkg::X_W-1:0]   x_sample_i,
  input  logic signed [mwlf_pkg::Y_W-1:0]   y_sample_i,
  input  mwlf_pkg::cmd_t                    cmd_i,
  input  logic                              out_stall_i,
  output mwlf_pkg::status_t                 status_o,
  output logic                              out_valid_o,
  output logic signed [mwlf_pkg::RES_W-1:0] slope_o,
  output logic signed [mwlf_pkg::RES_W-1:0] intercept_o,
  output logic                              fit_valid_o,
  output logic                              degenerate_o
);
  import mwlf_pkg::*;

  localparam int PTR_W = $clog2(WINDOW_MAX);
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  // Sums of y share the width of sums of x: both fields are 24 bits
  localparam int SX_W  = X_W + PTR_W;
  localparam int SXX_W = 2 * X_W + PTR_W;
  localparam int PP_W  = MUL_HALF + SX_W;
  localparam int NUM_W = SXX_W + SX_W + 1;

  // Window register and history
  logic [WS_W-1:0]         ws_q;
  logic [PTR_W-1:0]        wp_q, wp_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [SX_W-1:0]  sx_q, sy_q;
  logic signed [SXX_W-1:0] sxx_q, sxy_q;

  logic signed [X_W-1:0]   x_mem [WINDOW_MAX];
  logic signed [Y_W-1:0]   y_mem [WINDOW_MAX];

  // Current transaction
  logic signed [X_W-1:0]   x_q, old_x_q;
  logic signed [Y_W-1:0]   y_q, old_y_q;
  logic [PTR_W-1:0]        p_q, p_d;

  logic [CNT_W-1:0]        win;
  logic                    full;
  logic [CNT_W-1:0]        p_next;

  logic signed [X_W-1:0]     u_x;
  logic signed [Y_W-1:0]     u_y;
  logic signed [2*X_W-1:0]   sq;
  logic signed [X_W+Y_W-1:0] xy;

  // Product pipeline
  logic signed [SXX_W-1:0] a_val;
  logic signed [SX_W-1:0]  b_val;
  logic                    a_sub;
  logic [SXX_W-1:0]        a_mag;
  logic [SX_W-1:0]         b_mag;
  logic [MUL_HALF-1:0]     a_half;
  logic [PP_W-1:0]         pp_d, pp_q;
  logic                    pp_hi_q, pp_neg_q, pp_vld_q;
  prod_e                   pp_sel_q;
  logic [NUM_W-1:0]        term_abs, term;
  logic [NUM_W-1:0]        d_acc_q, ns_acc_q, ni_acc_q;

  // Divider and results
  logic                    div_done;
  logic [QUOT_W-1:0]       div_quot;
  logic                    div_slope_q;
  logic [RES_W-1:0]        slope_q, icpt_q;
  logic                    few, d_zero;

  logic                    out_valid_q;
  logic [RES_W-1:0]        out_slope_q, out_icpt_q;
  logic                    out_fit_q, out_degen_q;

  // Clamp the window register between the minimum sample count and the ring depth
  always_comb begin
    if (32'(ws_q) < 32'(MIN_SAMPLES)) begin
      win = CNT_W'(MIN_SAMPLES);
    end else if (32'(ws_q) > 32'(WINDOW_MAX)) begin
      win = CNT_W'(WINDOW_MAX);
    end else begin
      win = CNT_W'(ws_q);
    end
  end

  // Slot for this transaction and the pointer after it
  assign p_d    = (CNT_W'(wp_q) >= win) ? '0 : wp_q;
  assign p_next = CNT_W'(p_q) + 1'b1;
  assign wp_d   = (p_next >= win) ? '0 : p_next[PTR_W-1:0];
  assign full   = cnt_q >= win;
  assign cnt_d  = full ? win : cnt_q + 1'b1;

  // Square and cross product of the sample entering or leaving
  assign u_x = cmd_i.upd_new ? x_q : old_x_q;
  assign u_y = cmd_i.upd_new ? y_q : old_y_q;
  assign sq  = u_x * u_x;
  assign xy  = u_x * u_y;

  // Window register, pointer, count and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q  <= WS_RESET;
      wp_q  <= '0;
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
    end else if (cfg_we_i) begin
      ws_q  <= cfg_wdata_i;
      wp_q  <= '0;
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      sxy_q <= '0;
    end else if (cmd_i.upd_old && full) begin
      sx_q  <= sx_q - SX_W'(u_x);
      sy_q  <= sy_q - SX_W'(u_y);
      sxx_q <= sxx_q - SXX_W'(sq);
      sxy_q <= sxy_q - SXX_W'(xy);
    end else if (cmd_i.upd_new) begin
      sx_q  <= sx_q + SX_W'(u_x);
      sy_q  <= sy_q + SX_W'(u_y);
      sxx_q <= sxx_q + SXX_W'(sq);
      sxy_q <= sxy_q + SXX_W'(xy);
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
    end
  end

  // Latch the sample and its slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= x_sample_i;
      y_q <= y_sample_i;
      p_q <= p_d;
    end
  end

  // Ring: read the oldest sample on load, write the new one on update
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd_new) begin
      x_mem[p_q] <= x_q;
      y_mem[p_q] <= y_q;
    end
    if (cmd_i.load) begin
      old_x_q <= x_mem[p_d];
      old_y_q <= y_mem[p_d];
    end
  end

  // Select the operands of the requested product
  always_comb begin
    case (cmd_i.mul_sel)
      PR_N_SXX: begin
        a_val = sxx_q;
        b_val = SX_W'(cnt_q);
        a_sub = 1'b0;
      end
      PR_SX_SX: begin
        a_val = SXX_W'(sx_q);
        b_val = sx_q;
        a_sub = 1'b1;
      end
      PR_N_SXY: begin
        a_val = sxy_q;
        b_val = SX_W'(cnt_q);
        a_sub = 1'b0;
      end
      PR_SX_SY: begin
        a_val = SXX_W'(sy_q);
        b_val = sx_q;
        a_sub = 1'b1;
      end
      PR_SXX_SY: begin
        a_val = sxx_q;
        b_val = sy_q;
        a_sub = 1'b0;
      end
      PR_SX_SXY: begin
        a_val = sxy_q;
        b_val = sx_q;
        a_sub = 1'b1;
      end
      default: begin
        a_val = '0;
        b_val = '0;
        a_sub = 1'b0;
      end
    endcase
  end

  // Multiply one half of the wide magnitude by the narrow magnitude
  assign a_mag  = a_val[SXX_W-1] ? SXX_W'(-a_val) : a_val;
  assign b_mag  = b_val[SX_W-1] ? SX_W'(-b_val) : b_val;
  assign a_half = cmd_i.mul_hi ? MUL_HALF'(a_mag[SXX_W-1:MUL_HALF]) : a_mag[MUL_HALF-1:0];
  assign pp_d   = a_half * b_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_vld_q <= 1'b0;
    end else begin
      pp_vld_q <= cmd_i.mul_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      pp_q     <= pp_d;
      pp_hi_q  <= cmd_i.mul_hi;
      pp_neg_q <= a_val[SXX_W-1] ^ b_val[SX_W-1] ^ a_sub;
      pp_sel_q <= cmd_i.mul_sel;
    end
  end

  // Accumulate the signed partial product into its numerator
  assign term_abs = pp_hi_q ? (NUM_W'(pp_q) << MUL_HALF) : NUM_W'(pp_q);
  assign term     = pp_neg_q ? NUM_W'(-term_abs) : term_abs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      d_acc_q  <= '0;
      ns_acc_q <= '0;
      ni_acc_q <= '0;
    end else if (pp_vld_q) begin
      case (pp_sel_q)
        PR_N_SXX, PR_SX_SX: begin
          d_acc_q <= d_acc_q + term;
        end
        PR_N_SXY, PR_SX_SY: begin
          ns_acc_q <= ns_acc_q + term;
        end
        PR_SXX_SY, PR_SX_SXY: begin
          ni_acc_q <= ni_acc_q + term;
        end
        default: begin
        end
      endcase
    end
  end

  // Shared divider for slope and intercept
  mwlf_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .slope_i (cmd_i.div_slope),
    .num_i   (cmd_i.div_slope ? ns_acc_q : ni_acc_q),
    .den_i   (d_acc_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Capture each quotient where it belongs
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_slope_q <= cmd_i.div_slope;
    end
    if (div_done) begin
      if (div_slope_q) begin
        slope_q <= div_quot;
      end else begin
        icpt_q <= div_quot;
      end
    end
  end

  assign few    = cnt_q < CNT_W'(MIN_SAMPLES);
  assign d_zero = (d_acc_q == '0);

  // Result register: holds while the consumer stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_slope_q <= (few || d_zero) ? '0 : slope_q;
      out_icpt_q  <= (few || d_zero) ? '0 : icpt_q;
      out_fit_q   <= !few;
      out_degen_q <= !few && d_zero;
    end
  end

  assign status_o.few      = few;
  assign status_o.d_zero   = d_zero;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign slope_o      = out_slope_q;
  assign intercept_o  = out_icpt_q;
  assign fit_valid_o  = out_fit_q;
  assign degenerate_o = out_degen_q;

endmodule

>>> rtl/mwlf_ctrl.sv
// Controller: sequences sum update, products, two divisions and the result load.
module mwlf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  mwlf_pkg::status_t status_i,
  output mwlf_pkg::cmd_t    cmd_o,
  output logic              in_stall_o
);
  import mwlf_pkg::*;

  ctrl_state_e          state_q, state_d;
  logic [MUL_CNT_W-1:0] mul_cnt_q, mul_cnt_d;

  // State and product counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mul_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      mul_cnt_q <= mul_cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    mul_cnt_d     = '0;
    cmd_o         = '0;
    cmd_o.mul_sel = prod_e'(mul_cnt_q[MUL_CNT_W-1:1]);
    cmd_o.mul_hi  = mul_cnt_q[0];
    in_stall_o    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPD_OLD;
        end
      end
      ST_UPD_OLD: begin
        cmd_o.upd_old = 1'b1;
        state_d       = ST_UPD_NEW;
      end
      ST_UPD_NEW: begin
        cmd_o.upd_new = 1'b1;
        state_d       = ST_CHECK_N;
      end
      ST_CHECK_N: begin
        state_d = status_i.few ? ST_OUT : ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_go = 1'b1;
        if (mul_cnt_q == MUL_CNT_W'(MUL_OPS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          mul_cnt_d = mul_cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_CHECK_D;
      end
      ST_CHECK_D: begin
        state_d = status_i.d_zero ? ST_OUT : ST_DIV_S;
      end
      ST_DIV_S: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_slope = 1'b1;
        state_d         = ST_WAIT_S;
      end
      ST_WAIT_S: begin
        if (status_i.div_done) state_d = ST_DIV_I;
      end
      ST_DIV_I: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_WAIT_I;
      end
      ST_WAIT_I: begin
        if (status_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/moving_window_line_fit.sv
// Top level of the moving-window least-squares line fit.
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o   x_sample_i, y_sample_i (Q12.12)
//  out      output     out_valid_o / out_stall_i slope_o, intercept_o (Q16.16),
//                                                fit_valid_o, degenerate_o
//  cfg      input      cfg_we_i                  cfg_wdata_i (window size)
//
// One transaction at a time; a full fit runs the 12-step product sequencer and the two
// 33-step restoring divisions. With fewer than five samples held the result is loaded
// without products or divisions; with all x equal it is loaded without divisions.
// Reset clears the window register to 20 and empties the history; no clearing pass.
// A stalled result waits in the output register while the next sample is accepted
// and worked on; that sample's result then waits until the register is taken.
module moving_window_line_fit #(
  parameter int WINDOW_MAX = mwlf_pkg::WINDOW_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic        [mwlf_pkg::WS_W-1:0]  cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [mwlf_pkg::X_W-1:0]   x_sample_i,
  input  logic signed [mwlf_pkg::Y_W-1:0]   y_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [mwlf_pkg::RES_W-1:0] slope_o,
  output logic signed [mwlf_pkg::RES_W-1:0] intercept_o,
  output logic                              fit_valid_o,
  output logic                              degenerate_o
);
  import mwlf_pkg::*;

  cmd_t    cmd;
  status_t status;

  mwlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  mwlf_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .x_sample_i   (x_sample_i),
    .y_sample_i   (y_sample_i),
    .cmd_i        (cmd),
    .out_stall_i  (out_stall_i),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .slope_o      (slope_o),
    .intercept_o  (intercept_o),
    .fit_valid_o  (fit_valid_o),
    .degenerate_o (degenerate_o)
  );

  // Never overwrite a result that is still waiting
  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a pending result");

  // Divider cannot finish in the cycle after it starts
  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> !status.div_done)
    else $error("divider finished too early");

  // Block is busy right after taking a sample
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second sample accepted while one is in work");

  // Forced results carry zero slope and intercept
  a_forced_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (degenerate_o || !fit_valid_o)) |-> (slope_o == '0 && intercept_o == '0))
    else $error("forced result is not zero");

  // Degenerate only with a full enough window
  a_degen_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> fit_valid_o)
    else $error("degenerate flag without a fit");

endmodule

>>> verif/moving_window_line_fit_tb.sv
// Self-checking testbench for the moving-window least-squares line fit.
module moving_window_line_fit_tb;
  import mwlf_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int CLK_PERIOD     = 2 * CLK_HALF;
  localparam int RESET_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int RING_DEPTH     = WINDOW_MAX_DEF;
  localparam int SETTLE_CYCLES  = 100;
  localparam int LONG_HOLD      = 400;
  localparam int PHASE_COUNT    = 9;
  localparam int PHASE_ITEMS    = 100;
  localparam int RANDOM_WINDOW  = -1;

  localparam logic signed [X_W-1:0] X_MIN = 24'sh800000;
  localparam logic signed [X_W-1:0] X_MAX = 24'sh7FFFFF;

  typedef struct packed {
    logic signed [RES_W-1:0] slope;
    logic signed [RES_W-1:0] intercept;
    logic                    fit_valid;
    logic                    degenerate;
  } fit_result_t;

  localparam fit_result_t NO_FIT    = '{32'sd0, 32'sd0, 1'b0, 1'b0};
  localparam fit_result_t FLAT_FIT  = '{32'sd0, 32'sd0, 1'b1, 1'b1};
  localparam fit_result_t PREDICTED = NO_FIT;

  typedef struct {
    bit                    cfg_wr;
    logic [WS_W-1:0]       cfg_val;
    logic signed [X_W-1:0] x;
    logic signed [Y_W-1:0] y;
    bit                    typed;
    fit_result_t           want;
  } fit_stim_row_t;

  typedef enum int {
    BURST_FULL,
    BURST_LINE,
    BURST_NEAR,
    BURST_FLAT_X,
    BURST_EDGE
  } burst_kind_e;

  // DUT connections
  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    cfg_we_i    = 1'b0;
  logic [WS_W-1:0]         cfg_wdata_i = '0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic signed [X_W-1:0]   x_sample_i  = '0;
  logic signed [Y_W-1:0]   y_sample_i  = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [RES_W-1:0] slope_o;
  logic signed [RES_W-1:0] intercept_o;
  logic                    fit_valid_o;
  logic                    degenerate_o;

  // Predictor state
  logic [WS_W-1:0] win_reg = WS_RESET;
  longint          hist_x [RING_DEPTH];
  longint          hist_y [RING_DEPTH];
  int unsigned     wr_ptr  = 0;
  int unsigned     held    = 0;
  longint          acc_x   = 0;
  longint          acc_y   = 0;
  longint          acc_xx  = 0;
  longint          acc_xy  = 0;

  fit_result_t expected_fits [$];
  int          fit_errors = 0;

  // Idle control
  int unsigned send_idle_pct   = 0;
  int unsigned stall_pct       = 0;
  logic        long_hold_req   = 1'b0;
  logic        long_hold_taken = 1'b0;
  int unsigned hold_left       = 0;

  // Directed stimulus: extremes, short history, flat x, window clamping, saturation
  fit_stim_row_t dir_rows [25] = '{
    '{1'b0, 6'd0,  X_MIN,      X_MIN,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  X_MAX,      X_MAX,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  24'sd0,     24'sd0,     1'b1, NO_FIT},
    '{1'b0, 6'd0,  24'sd1,     -24'sd1,    1'b1, NO_FIT},
    '{1'b0, 6'd0,  -24'sd1,    X_MAX,      1'b0, PREDICTED},
    '{1'b0, 6'd0,  24'sd4096,  -24'sd4096, 1'b0, PREDICTED},
    '{1'b1, 6'd5,  24'sd100,   24'sd5,     1'b1, NO_FIT},
    '{1'b0, 6'd0,  24'sd100,   X_MIN,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  24'sd100,   X_MAX,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  24'sd100,   24'sd0,     1'b1, NO_FIT},
    '{1'b0, 6'd0,  24'sd100,   24'sd7,     1'b1, FLAT_FIT},
    '{1'b0, 6'd0,  24'sd101,   X_MAX,      1'b0, PREDICTED},
    '{1'b0, 6'd0,  24'sd101,   X_MIN,      1'b0, PREDICTED},
    '{1'b0, 6'd0,  X_MIN,      24'sd0,     1'b0, PREDICTED},
    '{1'b1, 6'd0,  X_MAX,      X_MAX,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  X_MAX,      24'sd0,     1'b1, NO_FIT},
    '{1'b0, 6'd0,  X_MAX,      X_MIN,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  X_MAX,      24'sd1,     1'b1, NO_FIT},
    '{1'b0, 6'd0,  X_MAX,      X_MIN,      1'b1, FLAT_FIT},
    '{1'b1, 6'd63, X_MIN,      X_MAX,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  X_MAX,      X_MIN,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  X_MIN,      X_MAX,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  X_MAX,      X_MIN,      1'b1, NO_FIT},
    '{1'b0, 6'd0,  24'sd0,     24'sd1,     1'b0, PREDICTED},
    '{1'b0, 6'd0,  X_MIN,      X_MIN,      1'b0, PREDICTED}
  };

  int phase_window [PHASE_COUNT] = '{5, 32, 63, 0, 20, 12, RANDOM_WINDOW, RANDOM_WINDOW, 33};

  moving_window_line_fit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .x_sample_i   (x_sample_i),
    .y_sample_i   (y_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slope_o      (slope_o),
    .intercept_o  (intercept_o),
    .fit_valid_o  (fit_valid_o),
    .degenerate_o (degenerate_o)
  );

  // Generate the clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Clamp the window register to the usable range
  function automatic int unsigned eff_window();
    int unsigned w;
    w = 32'(win_reg);
    if (w < MIN_SAMPLES) w = MIN_SAMPLES;
    if (w > RING_DEPTH) w = RING_DEPTH;
    return w;
  endfunction

  // Divide, round to nearest with ties away from zero, saturate to Q16.16
  function automatic logic signed [RES_W-1:0] round_div_sat(input logic signed [191:0] num,
                                                            input logic signed [191:0] den);
    logic signed [191:0] mag;
    logic signed [191:0] quo;
    logic                neg;
    neg = (num < 0);
    mag = neg ? -num : num;
    quo = ((mag <<< 1) + den) / (den <<< 1);
    if (!neg) begin
      if (quo > 192'sh7FFFFFFF) quo = 192'sh7FFFFFFF;
      return quo[RES_W-1:0];
    end
    if (quo > 192'sh80000000) quo = 192'sh80000000;
    quo = -quo;
    return quo[RES_W-1:0];
  endfunction

  // Push one sample into the window and fit the line through it
  function automatic fit_result_t line_fit_predict(input logic signed [X_W-1:0] xs,
                                                   input logic signed [Y_W-1:0] ys);
    int unsigned         w;
    int unsigned         p;
    longint              xv;
    longint              yv;
    longint              ox;
    longint              oy;
    logic signed [191:0] n_w, sx_w, sy_w, sxx_w, sxy_w, det, num_s, num_i;
    fit_result_t         res;
    w  = eff_window();
    p  = (wr_ptr >= w) ? 0 : wr_ptr;
    xv = longint'(xs);
    yv = longint'(ys);
    // Drop the oldest sample once the window is full
    if (held >= w) begin
      ox = hist_x[p];
      oy = hist_y[p];
      acc_x  -= ox;
      acc_y  -= oy;
      acc_xx -= ox * ox;
      acc_xy -= ox * oy;
      held = w;
    end else begin
      held++;
    end
    hist_x[p] = xv;
    hist_y[p] = yv;
    acc_x  += xv;
    acc_y  += yv;
    acc_xx += xv * xv;
    acc_xy += xv * yv;
    wr_ptr = (p + 1 >= w) ? 0 : p + 1;

    res = NO_FIT;
    if (held < MIN_SAMPLES) return res;
    res.fit_valid = 1'b1;
    n_w   = 192'(held);
    sx_w  = 192'(acc_x);
    sy_w  = 192'(acc_y);
    sxx_w = 192'(acc_xx);
    sxy_w = 192'(acc_xy);
    det = n_w * sxx_w - sx_w * sx_w;
    if (det == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    num_s = n_w * sxy_w - sx_w * sy_w;
    num_i = sxx_w * sy_w - sx_w * sxy_w;
    res.slope     = round_div_sat(num_s <<< SLOPE_SHIFT, det);
    res.intercept = round_div_sat(num_i <<< ICPT_SHIFT, det);
    return res;
  endfunction

  // Offer one sample, hold it until accepted, then record its expected fit
  task automatic send_sample(input logic signed [X_W-1:0] xv, input logic signed [Y_W-1:0] yv,
                             input bit typed, input fit_result_t want);
    fit_result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_sample_i <= xv;
    y_sample_i <= yv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = line_fit_predict(xv, yv);
    expected_fits.insert(expected_fits.size(), typed ? want : pred);
  endtask

  // Stop sending and wait for every outstanding fit
  task automatic wait_fits_drained();
    in_valid_i <= 1'b0;
    while (expected_fits.size() != 0) @(posedge clk_i);
  endtask

  // Write the window register with the block idle; this also clears the history
  task automatic write_window(input logic [WS_W-1:0] val);
    wait_fits_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_reg = val;
    wr_ptr  = 0;
    held    = 0;
    acc_x   = 0;
    acc_y   = 0;
    acc_xx  = 0;
    acc_xy  = 0;
  endtask

  function automatic logic signed [X_W-1:0] pick_edge();
    case ($urandom_range(0, 4))
      0: return X_MIN;
      1: return X_MAX;
      2: return 24'sd0;
      3: return -24'sd1;
      default: return 24'sd1;
    endcase
  endfunction

  // Drive the receiver stall: one long hold on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_left       <= LONG_HOLD;
      out_stall_i     <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fit_errors++;
    end
  endfunction

  // Compare each accepted result transaction with the oldest expected fit
  always @(posedge clk_i) begin
    fit_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_fits.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual slope %0d intercept %0d",
                 $time, slope_o, intercept_o);
        fit_errors++;
      end else begin
        want = expected_fits.pop_front();
        check_field("slope", want.slope, slope_o);
        check_field("intercept", want.intercept, intercept_o);
        check_field("fit_valid", want.fit_valid, fit_valid_o);
        check_field("degenerate", want.degenerate, degenerate_o);
      end
    end
  end

  // Main sequence
  initial begin
    burst_kind_e           kind;
    int unsigned           burst_len;
    int unsigned           sent;
    int                    a_slope;
    int                    x_step;
    int                    noise;
    longint                y_line;
    logic signed [X_W-1:0] bx;
    logic signed [Y_W-1:0] by;
    logic signed [X_W-1:0] xv;
    logic signed [Y_W-1:0] yv;
    logic [WS_W-1:0]       wval;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg_wr) write_window(dir_rows[i].cfg_val);
      send_sample(dir_rows[i].x, dir_rows[i].y, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random bursts, one window setting and idle mix per phase
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wval = (phase_window[ph] == RANDOM_WINDOW) ? WS_W'($urandom_range(0, 63))
                                                 : WS_W'(phase_window[ph]);
      write_window(wval);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind      = burst_kind_e'($urandom_range(0, 4));
        burst_len = $urandom_range(1, 2 * eff_window() + 4);
        bx        = X_W'($urandom);
        by        = Y_W'($urandom);
        x_step    = $urandom_range(1, 4096);
        a_slope   = int'($urandom_range(0, 65535)) - 32768;
        for (int k = 0; k < burst_len && sent < PHASE_ITEMS; k++) begin
          case (kind)
            BURST_FULL: begin
              xv = X_W'($urandom);
              yv = Y_W'($urandom);
            end
            BURST_LINE: begin
              noise  = int'($urandom_range(0, 63)) - 32;
              xv     = bx + X_W'(k * x_step);
              y_line = longint'(by) + ((longint'(a_slope) * (k * x_step)) >>> 12) + noise;
              yv     = y_line[Y_W-1:0];
            end
            BURST_NEAR: begin
              xv = bx + X_W'($urandom_range(0, 3) == 0);
              yv = Y_W'($urandom);
            end
            BURST_FLAT_X: begin
              xv = bx;
              yv = by + Y_W'($urandom_range(0, 255));
            end
            default: begin
              xv = pick_edge();
              yv = pick_edge();
            end
          endcase
          send_sample(xv, yv, 1'b0, PREDICTED);
          sent++;
          // Hold off the receiver long enough to back up the input
          if (ph == 2 && sent == 30) long_hold_req <= 1'b1;
          // Pause the sender until every fit is back
          if (ph == 5 && sent == 50) wait_fits_drained();
        end
      end
    end

    wait_fits_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fit_errors == 0 && expected_fits.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
